// ===== src/fea_pkg.sv =====
// Shared types and constants for the free extent allocator.
package fea_pkg;

    localparam int MAX_EXTENTS_DEF  = 64;
    localparam int ADDR_BITS_DEF    = 20;
    localparam int SPLIT_MARGIN_DEF = 8;
    localparam int FIELD_BITS       = 20;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [FIELD_BITS-1:0] byte_count;
        logic [FIELD_BITS-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [FIELD_BITS-1:0] result_address;
        logic [1:0]            status;
        logic [FIELD_BITS-1:0] free_bytes;
    } t_rsp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture request, clear scan index (set to count for a zero size)
        logic scan;     // read entry at index, advance
        logic alloc;    // evaluate read entry for allocate
        logic freechk;  // evaluate read entry for free position search
        logic apply;    // perform the chosen update
        logic shift;    // one step of a table shift
        logic finish;   // build the result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_end;   // index reached count
        logic found;      // exact hit (alloc) or position found (free)
        logic shift_end;  // shift finished
        logic need_shift; // apply requires a shift
    } t_sts;

endpackage

// ===== src/fea_ctrl.sv =====
// Controller state machine for the free extent allocator.
module fea_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  fea_pkg::t_sts i_sts,
    input  logic          i_op,
    output fea_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_APPLY = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.scan_end) begin
                    n_state = S_APPLY;
                end else begin
                    o_cmd.scan = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.alloc   = (i_op == fea_pkg::OP_ALLOC);
                o_cmd.freechk = (i_op == fea_pkg::OP_FREE);
                n_state = i_sts.found ? S_APPLY : S_READ;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = i_sts.need_shift ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                if (i_sts.shift_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

// ===== src/fea_dpath.sv =====
// Datapath of the free extent allocator: extent table, scan and update logic.
module fea_dpath #(
    parameter int MAX_EXTENTS  = fea_pkg::MAX_EXTENTS_DEF,
    parameter int ADDR_BITS    = fea_pkg::ADDR_BITS_DEF,
    parameter int SPLIT_MARGIN = fea_pkg::SPLIT_MARGIN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fea_pkg::t_req i_req,
    input  fea_pkg::t_cmd i_cmd,
    output fea_pkg::t_sts o_sts,
    output logic          o_op,
    output fea_pkg::t_rsp o_rsp
);

    localparam int FB = fea_pkg::FIELD_BITS;
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    // Width that holds an extent end without wrap.
    localparam int EW = ((ADDR_BITS > FB) ? ADDR_BITS : FB) + 1;
    localparam logic [FB:0] MAXV = {1'b0, {FB{1'b1}}};
    localparam logic [CW-1:0] CMAX = CW'(MAX_EXTENTS);

    // Update kinds chosen at apply.
    typedef enum logic [2:0] {
        U_NONE, U_EXACT, U_SPLIT, U_JOIN2, U_JOINLO, U_JOINHI, U_INS
    } t_upd;

    logic [ADDR_BITS-1:0] r_base [MAX_EXTENTS];
    logic [FB-1:0]        r_size [MAX_EXTENTS];

    logic                 r_op;
    logic [FB-1:0]        r_cnt;
    logic [ADDR_BITS-1:0] r_addr;
    logic [CW-1:0]        r_count, r_idx, r_pos;
    logic [FB-1:0]        r_total;
    logic [ADDR_BITS-1:0] r_rd_base, r_prev_base;
    logic [FB-1:0]        r_rd_size, r_prev_size;
    logic                 r_have_prev, r_have_split, r_found;
    logic [CW-1:0]        r_split;
    logic [ADDR_BITS-1:0] r_split_base;
    logic [FB-1:0]        r_split_size;
    logic [ADDR_BITS-1:0] r_hit_base;
    logic [CW-1:0]        r_sh_idx, r_sh_end;
    logic                 r_sh_up;
    logic [1:0]           r_status;
    logic [FB-1:0]        r_res;
    t_upd                 r_upd;
    fea_pkg::t_rsp        r_rsp;

    // Read-port and helper arithmetic.
    logic [FB:0]        split_need;
    logic [EW-1:0]      prev_end, req_end;
    logic               join_lo, join_hi, at_end;
    logic [FB+1:0]      sum3;
    logic [FB-1:0]      sum3_sat, sumlo_sat, sumhi_sat, tot_sat;
    logic [EW-1:0]      split_addr;
    logic [FB:0]        tot_add;

    function automatic logic [FB-1:0] sat(input logic [FB:0] v);
        sat = v[FB] ? MAXV[FB-1:0] : v[FB-1:0];
    endfunction

    assign split_need = {1'b0, r_cnt} + (FB+1)'(SPLIT_MARGIN);
    assign at_end     = (r_idx == r_count);
    assign prev_end   = EW'(r_prev_base) + EW'(r_prev_size);
    assign req_end    = EW'(r_addr) + EW'(r_cnt);
    assign join_lo    = r_have_prev && (prev_end == EW'(r_addr));
    assign join_hi    = r_found && (req_end == EW'(r_rd_base));
    assign sum3       = {2'b0, r_prev_size} + {2'b0, r_cnt} + {2'b0, r_rd_size};
    assign sum3_sat   = (sum3 > (FB+2)'(MAXV)) ? MAXV[FB-1:0] : sum3[FB-1:0];
    assign sumlo_sat  = sat({1'b0, r_prev_size} + {1'b0, r_cnt});
    assign sumhi_sat  = sat({1'b0, r_rd_size} + {1'b0, r_cnt});
    assign tot_add    = {1'b0, r_total} + {1'b0, r_cnt};
    assign tot_sat    = sat(tot_add);
    assign split_addr = EW'(r_split_base) + EW'(r_split_size - r_cnt);

    // Status to the controller.
    always_comb begin
        o_sts.scan_end   = at_end;
        o_sts.found      = 1'b0;
        o_sts.shift_end  = (r_sh_idx == r_sh_end);
        o_sts.need_shift = 1'b0;
        if (i_cmd.alloc) begin
            o_sts.found = (r_rd_size == r_cnt);
        end else if (i_cmd.freechk) begin
            o_sts.found = !(r_rd_base < r_addr);
        end
        if (i_cmd.apply && r_status == fea_pkg::ST_DONE) begin
            if (r_op == fea_pkg::OP_ALLOC) begin
                o_sts.need_shift = r_found;
            end else begin
                o_sts.need_shift = (join_lo && join_hi) ||
                                   (!join_lo && !join_hi && r_count != CMAX);
            end
        end
    end

    // Table read address: scan index, or the neighbor during a shift.
    logic [IW-1:0] ra;

    always_comb begin
        ra = r_idx[IW-1:0];
        if (i_cmd.shift) begin
            ra = r_sh_up ? IW'(r_sh_idx - CW'(1)) : IW'(r_sh_idx + CW'(1));
        end
    end

    // Registered read; the read entry holds until the next scan or shift step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan || i_cmd.shift) begin
            r_rd_base <= r_base[ra];
            r_rd_size <= r_size[ra];
        end
    end

    // Shift pipeline: read one cycle, write the next.
    logic          r_sh_wv;
    logic [IW-1:0] r_sh_wa;
    logic          r_ap_we;
    logic [IW-1:0] r_ap_wa;
    logic [ADDR_BITS-1:0] r_ap_b;
    logic [FB-1:0]        r_ap_s;

    always_ff @(posedge i_clk) begin
        if (r_sh_wv) begin
            r_base[r_sh_wa] <= r_rd_base;
            r_size[r_sh_wa] <= r_rd_size;
        end else if (r_ap_we) begin
            r_base[r_ap_wa] <= r_ap_b;
            r_size[r_ap_wa] <= r_ap_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_sh_wv <= 1'b0;
            r_ap_we <= 1'b0;
            r_sh_idx <= '0;
            r_sh_end <= '0;
        end else begin
            r_sh_wv <= i_cmd.shift;
            r_sh_wa <= IW'(r_sh_idx);
            r_ap_we <= 1'b0;
            if (i_cmd.shift) begin
                r_sh_idx <= r_sh_up ? r_sh_idx - CW'(1) : r_sh_idx + CW'(1);
            end
            if (i_cmd.load) begin
                r_op   <= i_req.operation;
                r_cnt  <= i_req.byte_count;
                r_addr <= ADDR_BITS'(i_req.block_address);
                r_idx  <= '0;
                r_have_prev  <= 1'b0;
                r_have_split <= 1'b0;
                r_found      <= 1'b0;
                r_upd        <= U_NONE;
                r_res        <= '0;
                r_status     <= (i_req.byte_count == '0) ? fea_pkg::ST_ZERO
                                                         : fea_pkg::ST_DONE;
                if (i_req.byte_count == '0) begin
                    r_idx <= r_count;
                end
            end
            if (i_cmd.scan) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.alloc) begin
                if (r_rd_size == r_cnt) begin
                    r_found    <= 1'b1;
                    r_pos      <= r_idx - CW'(1);
                    r_hit_base <= r_rd_base;
                end else if (!r_have_split && {1'b0, r_rd_size} >= split_need) begin
                    r_have_split <= 1'b1;
                    r_split      <= r_idx - CW'(1);
                    r_split_base <= r_rd_base;
                    r_split_size <= r_rd_size;
                end
            end
            if (i_cmd.freechk) begin
                if (!(r_rd_base < r_addr)) begin
                    r_found <= 1'b1;
                    r_pos   <= r_idx - CW'(1);
                end else begin
                    r_have_prev <= 1'b1;
                    r_prev_base <= r_rd_base;
                    r_prev_size <= r_rd_size;
                    r_pos       <= r_idx;
                end
            end
            if (i_cmd.apply && r_status == fea_pkg::ST_DONE) begin
                if (r_op == fea_pkg::OP_ALLOC) begin
                    if (r_found) begin
                        r_res    <= FB'(r_hit_base);
                        r_total  <= (r_total >= r_cnt) ? r_total - r_cnt : '0;
                        r_sh_up  <= 1'b0;
                        r_sh_idx <= r_pos;
                        r_sh_end <= r_count - CW'(1);
                        r_count  <= r_count - CW'(1);
                    end else if (r_have_split) begin
                        r_ap_we  <= 1'b1;
                        r_ap_wa  <= r_split[IW-1:0];
                        r_ap_b   <= r_split_base;
                        r_ap_s   <= r_split_size - r_cnt;
                        r_res    <= FB'(split_addr[ADDR_BITS-1:0]);
                        r_total  <= (r_total >= r_cnt) ? r_total - r_cnt : '0;
                    end else begin
                        r_status <= fea_pkg::ST_NOFIT;
                    end
                end else begin
                    if (!r_found) begin
                        r_pos <= r_count;
                    end
                    if (join_lo && join_hi) begin
                        r_ap_we  <= 1'b1;
                        r_ap_wa  <= IW'(r_pos - CW'(1));
                        r_ap_b   <= r_prev_base;
                        r_ap_s   <= sum3_sat;
                        r_sh_up  <= 1'b0;
                        r_sh_idx <= r_pos;
                        r_sh_end <= r_count - CW'(1);
                        r_count  <= r_count - CW'(1);
                        r_total  <= tot_sat;
                    end else if (join_lo) begin
                        r_ap_we <= 1'b1;
                        r_ap_wa <= IW'(r_pos - CW'(1));
                        r_ap_b  <= r_prev_base;
                        r_ap_s  <= sumlo_sat;
                        r_total <= tot_sat;
                    end else if (join_hi) begin
                        r_ap_we <= 1'b1;
                        r_ap_wa <= IW'(r_pos);
                        r_ap_b  <= r_addr;
                        r_ap_s  <= sumhi_sat;
                        r_total <= tot_sat;
                    end else if (r_count == CMAX) begin
                        r_status <= fea_pkg::ST_FULL;
                    end else begin
                        // Shift up from the top, then write the new entry.
                        r_sh_up  <= 1'b1;
                        r_sh_idx <= r_count;
                        r_sh_end <= r_found ? r_pos : r_count;
                        r_count  <= r_count + CW'(1);
                        r_total  <= tot_sat;
                        r_upd    <= U_INS;
                    end
                end
            end
            // After an insert shift, store the new extent at its place.
            if (i_cmd.finish && r_upd == U_INS) begin
                r_ap_we <= 1'b1;
                r_ap_wa <= IW'(r_sh_end);
                r_ap_b  <= r_addr;
                r_ap_s  <= r_cnt;
            end
            if (i_cmd.finish) begin
                r_rsp.result_address <= r_res;
                r_rsp.status         <= r_status;
                r_rsp.free_bytes     <= r_total;
            end
        end
    end

    assign o_op  = r_op;
    assign o_rsp = r_rsp;

endmodule

// ===== src/free_extent_allocator.sv =====
// Top level of the free extent allocator.
//
//  Channel | Direction | Handshake        | Payload
//  request | in        | i_valid/o_stall  | i_req  (fea_pkg::t_req)
//  result  | out       | o_valid/i_stall  | o_rsp  (fea_pkg::t_rsp)
//
// One request at a time. A request scans the stored extents one by one through
// the single table read port; the scan stops early at an exact fit or at the
// insert position. A table shift then moves the affected entries one at a time.
// No clearing pass after reset.
// A stalled result holds; the next request is taken once it has transferred.
module free_extent_allocator #(
    parameter int MAX_EXTENTS  = fea_pkg::MAX_EXTENTS_DEF,
    parameter int ADDR_BITS    = fea_pkg::ADDR_BITS_DEF,
    parameter int SPLIT_MARGIN = fea_pkg::SPLIT_MARGIN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  fea_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output fea_pkg::t_rsp o_rsp
);

    fea_pkg::t_cmd cmd;
    fea_pkg::t_sts sts;
    logic          op;

    fea_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .i_sts(sts), .i_op(op), .o_cmd(cmd)
    );

    fea_dpath #(
        .MAX_EXTENTS(MAX_EXTENTS), .ADDR_BITS(ADDR_BITS),
        .SPLIT_MARGIN(SPLIT_MARGIN)
    ) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(i_req), .i_cmd(cmd), .o_sts(sts),
        .o_op(op), .o_rsp(o_rsp)
    );

endmodule

// ===== tb/sv/tb_free_extent_allocator.sv =====
// Self-checking testbench for the free extent allocator.
`timescale 1ns / 100ps

module tb_free_extent_allocator;

    localparam int NUM_EXTENTS = fea_pkg::MAX_EXTENTS_DEF;
    localparam int MARGIN      = fea_pkg::SPLIT_MARGIN_DEF;
    localparam logic [19:0] SAT_MAX = 20'hFFFFF;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    fea_pkg::t_req i_req;
    logic          o_valid;
    logic          i_stall;
    fea_pkg::t_rsp o_rsp;

    free_extent_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    // Model copy of the extent table.
    logic [19:0] mdl_base [NUM_EXTENTS];
    logic [19:0] mdl_size [NUM_EXTENTS];
    int          mdl_count;
    logic [19:0] mdl_free;

    fea_pkg::t_req pending_reqs[$];
    fea_pkg::t_rsp expected_rsps[$];
    int            error_count;

    bit   hold_sender;
    int   long_hold_cycles;
    int   gap_left;
    int   rx_gap_left;

    function automatic logic [19:0] sat_add(longint unsigned v);
        return (v > SAT_MAX) ? SAT_MAX : v[19:0];
    endfunction

    task automatic drop_entry(int p);
        for (int i = p; i + 1 < mdl_count; i++) begin
            mdl_base[i] = mdl_base[i+1];
            mdl_size[i] = mdl_size[i+1];
        end
        mdl_count--;
    endtask

    // Compute the response to one request and update the model table.
    task automatic predict_allocator(fea_pkg::t_req r);
        fea_pkg::t_rsp e;
        int    p;
        int    split;
        bit    lo, hi;
        e = '0;
        if (r.byte_count == 0) begin
            e.status = fea_pkg::ST_ZERO;
        end else if (r.operation == fea_pkg::OP_ALLOC) begin
            split = -1;
            e.status = fea_pkg::ST_NOFIT;
            for (int i = 0; i < mdl_count; i++) begin
                if (mdl_size[i] == r.byte_count) begin
                    e.result_address = mdl_base[i];
                    e.status = fea_pkg::ST_DONE;
                    drop_entry(i);
                    split = -2;
                    break;
                end
                if (split == -1 && longint'(mdl_size[i]) >= longint'(r.byte_count) + MARGIN)
                    split = i;
            end
            if (split >= 0) begin
                mdl_size[split] = mdl_size[split] - r.byte_count;
                e.result_address = mdl_base[split] + mdl_size[split];
                e.status = fea_pkg::ST_DONE;
            end
            if (e.status == fea_pkg::ST_DONE)
                mdl_free = (mdl_free >= r.byte_count) ? mdl_free - r.byte_count : '0;
        end else begin
            p = 0;
            while (p < mdl_count && mdl_base[p] < r.block_address) p++;
            lo = p > 0 && (longint'(mdl_base[p-1]) + mdl_size[p-1] == longint'(r.block_address));
            hi = p < mdl_count &&
                 (longint'(r.block_address) + r.byte_count == longint'(mdl_base[p]));
            e.status = fea_pkg::ST_DONE;
            if (lo && hi) begin
                mdl_size[p-1] = sat_add(longint'(mdl_size[p-1]) + r.byte_count + mdl_size[p]);
                drop_entry(p);
            end else if (lo) begin
                mdl_size[p-1] = sat_add(longint'(mdl_size[p-1]) + r.byte_count);
            end else if (hi) begin
                mdl_base[p] = r.block_address;
                mdl_size[p] = sat_add(longint'(mdl_size[p]) + r.byte_count);
            end else if (mdl_count >= NUM_EXTENTS) begin
                e.status = fea_pkg::ST_FULL;
            end else begin
                for (int i = mdl_count; i > p; i--) begin
                    mdl_base[i] = mdl_base[i-1];
                    mdl_size[i] = mdl_size[i-1];
                end
                mdl_base[p] = r.block_address;
                mdl_size[p] = r.byte_count;
                mdl_count++;
            end
            if (e.status == fea_pkg::ST_DONE)
                mdl_free = sat_add(longint'(mdl_free) + r.byte_count);
        end
        e.free_bytes = mdl_free;
        expected_rsps.push_back(e);
    endtask

    function automatic fea_pkg::t_req make_req(logic op, logic [19:0] cnt, logic [19:0] addr);
        fea_pkg::t_req r;
        r.operation = op;
        r.byte_count = cnt;
        r.block_address = addr;
        return r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        if (k < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Driver: offers queued requests with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else if (i_valid && !o_stall) begin
            predict_allocator(i_req);
            void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && !hold_sender && pick_gap() == 0) begin
                i_req <= pending_reqs[0];
            end else begin
                i_valid <= 1'b0;
                gap_left <= pick_gap();
            end
        end else if (!i_valid) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                i_valid <= 1'b1;
                i_req <= pending_reqs[0];
            end
        end
    end

    // Monitor: random stalls, a long hold-off once, and response checking.
    always @(posedge i_clk) begin
        fea_pkg::t_rsp e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response %h", o_rsp);
                    error_count++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (o_rsp.result_address !== e.result_address) begin
                        $error("result_address expected %h actual %h",
                               e.result_address, o_rsp.result_address);
                        error_count++;
                    end
                    if (o_rsp.status !== e.status) begin
                        $error("status expected %h actual %h", e.status, o_rsp.status);
                        error_count++;
                    end
                    if (o_rsp.free_bytes !== e.free_bytes) begin
                        $error("free_bytes expected %h actual %h",
                               e.free_bytes, o_rsp.free_bytes);
                        error_count++;
                    end
                end
            end
            if (long_hold_cycles > 0) begin
                long_hold_cycles <= long_hold_cycles - 1;
                i_stall <= 1'b1;
            end else if (rx_gap_left > 0) begin
                rx_gap_left <= rx_gap_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                rx_gap_left <= pick_gap();
            end
        end
    end

    // Random free of a region at a multiple of 64 up to 16320, or anywhere.
    function automatic fea_pkg::t_req rand_free();
        logic [19:0] cnt, addr;
        int k;
        k = $urandom_range(0, 9);
        cnt = (k < 8) ? 20'($urandom_range(1, 300)) : 20'($urandom);
        if (k == 9) cnt = 20'($urandom_range(0, 3));
        addr = 20'($urandom_range(0, 255) * 64);
        if (k == 7) addr = 20'($urandom);
        return make_req(fea_pkg::OP_FREE, cnt, addr);
    endfunction

    function automatic fea_pkg::t_req rand_alloc();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7)
            return make_req(fea_pkg::OP_ALLOC, 20'($urandom_range(1, 200)), 20'($urandom));
        if (k < 9)
            return make_req(fea_pkg::OP_ALLOC, 20'($urandom_range(0, 16)), 20'($urandom));
        return make_req(fea_pkg::OP_ALLOC, 20'($urandom), 20'($urandom));
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    // Stimulus.
    initial begin
        error_count = 0;
        mdl_count = 0;
        mdl_free = '0;
        hold_sender = 0;
        long_hold_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero size, no fit, exact match, splits, merges, extremes.
        pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'd0, 20'hFFFFF));
        pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'd10, 20'd0));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd0, 20'd100));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd100, 20'd1000));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd50, 20'd2000));
        pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'd50, 20'd0));
        pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'd93, 20'd0));
        pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'd92, 20'd0));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd4, 20'd500));
        pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'd1, 20'd0));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd10, 20'd504));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd10, 20'd490));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd20, 20'd400));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd70, 20'd420));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'hFFFFF, 20'hFFFFF));
        pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'hFFFFF, 20'd0));
        pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'hFFFFF, 20'd0));
        pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'd1, 20'hFFFFF));
        wait_drained();

        // Fill the table to capacity, then hit the full case.
        for (int i = 0; i < NUM_EXTENTS + 2; i++)
            pending_reqs.push_back(make_req(fea_pkg::OP_FREE, 20'd3, 20'(200000 + i * 16)));
        // Long receiver hold-off while the sender keeps offering.
        long_hold_cycles = 400;
        for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_alloc());
        wait_drained();
        // Remove the size-3 extents again via exact-size allocations.
        for (int i = 0; i < NUM_EXTENTS + 2; i++)
            pending_reqs.push_back(make_req(fea_pkg::OP_ALLOC, 20'd3, 20'd0));

        // Random phases; sender pauses until all results are back between them.
        for (int ph = 0; ph < 11; ph++) begin
            for (int i = 0; i < 100; i++)
                pending_reqs.push_back(($urandom_range(0, 1)) ? rand_free() : rand_alloc());
            hold_sender = (ph == 5);
            if (hold_sender) begin
                while (i_valid || expected_rsps.size() > 0) @(posedge i_clk);
                hold_sender = 0;
            end
            wait_drained();
        end
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
